// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define MCSTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off while reset is asserted
`define MCSTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/mcstb_pkg.sv -----
// shared types and constants of the soft timer bank
package mcstb_pkg;

  // operation codes
  typedef enum logic [2:0] {
    MODE_ALLOC     = 3'd0,
    MODE_START     = 3'd1,
    MODE_CLOSE     = 3'd2,
    MODE_TICK_MAIN = 3'd3,
    MODE_TICK_SUB  = 3'd4,
    MODE_SERVICE   = 3'd5
  } mode_t;

  // field widths
  localparam int MODE_W = 3;
  localparam int ID_W   = 5;
  localparam int SRC_W  = 2;
  localparam int PER_W  = 32;
  localparam int CNT_W  = 32;

  // input tdata layout, lowest field first
  localparam int IN_MODE_LSB = 0;
  localparam int IN_ID_LSB   = IN_MODE_LSB + MODE_W;
  localparam int IN_SRC_LSB  = IN_ID_LSB + ID_W;
  localparam int IN_PER_LSB  = IN_SRC_LSB + SRC_W;
  localparam int IN_BITS     = IN_PER_LSB + PER_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout: ok, timer_number, any_main_running
  localparam int OUT_OK_BIT   = 0;
  localparam int OUT_NUM_LSB  = 1;
  localparam int OUT_MAIN_BIT = OUT_NUM_LSB + ID_W;
  localparam int OUT_BITS     = OUT_MAIN_BIT + 1;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // bank limits
  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int NEXP_W         = $clog2(MAX_RESULTS + 1);

  // width for slot number arithmetic, covers up to 64 slots
  localparam int CALC_W = 7;

endpackage

// ----- hw/rtl/multi_channel_soft_timer_bank_unit.sv -----
// top level of the soft timer bank: slot flags, period/count memory, scan sequencer
//
//   channel | dir | tdata                                   | side bits
//   in_     | in  | mode, timer_id, tick_source, period     | -
//   out_    | out | ok, timer_number, any_main_running      | tuser expired, tlast last
//
// allocate, start, close and unused modes pass through the done state to the output register.
// a tick or a service walks the period/count memory one slot per cycle over its
// single read port, except while an expiry waits on out_.
// one item is worked at a time; in_tready is high only between items.
// reset clears the slot flags and the allocate count; memory words are written by start.
module multi_channel_soft_timer_bank_unit #(
  parameter int NUM_TIMERS = mcstb_pkg::NUM_TIMERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: mode[2:0], timer_id[7:3], tick_source[9:8], period[41:10]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mcstb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: ok[0], timer_number[5:1], any_main_running[6]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mcstb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: expired[0]
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import mcstb_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [CNT_W-1:0] count;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // control and flag registers
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           alloc_r, alloc_nxt;
  logic [NUM_TIMERS-1:0]   running_r, running_nxt;
  logic [NUM_TIMERS-1:0]   source_r, source_nxt;
  logic                    is_srv_r, is_srv_nxt;
  logic                    tick_sub_r, tick_sub_nxt;
  logic [CW-1:0]           issue_idx_r, issue_idx_nxt;
  logic                    ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]           ev_idx_r, ev_idx_nxt;
  logic [NEXP_W-1:0]       nexp_r, nexp_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0]         pend_num_r, pend_num_nxt;
  logic                    fin_ok_r, fin_ok_nxt;
  logic [ID_W-1:0]         fin_num_r, fin_num_nxt;

  // output register
  logic                    out_vld_r, out_vld_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [ID_W-1:0]         out_num_r, out_num_nxt;
  logic                    out_exp_r, out_exp_nxt;
  logic                    out_main_r, out_main_nxt;
  logic                    out_last_r, out_last_nxt;

  // slot memory
  slot_t                   mem [NUM_TIMERS];
  slot_t                   rd_data_r;
  logic [IW-1:0]           rd_addr;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  slot_t                   mem_wdata;

  // decoded input and scan terms
  mode_t                   in_mode;
  logic [ID_W-1:0]         in_id;
  logic [SRC_W-1:0]        in_src;
  logic [PER_W-1:0]        in_per;
  logic                    in_acc;
  logic                    id_ok;
  logic [CALC_W-1:0]       id_m1;
  logic [IW-1:0]           id_idx;
  logic [CALC_W-1:0]       alloc_p1;
  logic [CALC_W-1:0]       ev_num;
  logic                    out_free;
  logic                    any_main;
  logic                    issue_more;
  logic                    ev_due;
  logic                    srv_hit;
  logic                    tick_hit;
  logic                    stall;

  // field extraction
  assign in_mode  = mode_t'(in_tdata[IN_MODE_LSB +: MODE_W]);
  assign in_id    = in_tdata[IN_ID_LSB +: ID_W];
  assign in_src   = in_tdata[IN_SRC_LSB +: SRC_W];
  assign in_per   = in_tdata[IN_PER_LSB +: PER_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // slot number checks for start and close
  assign id_ok    = (in_id != '0) && (CALC_W'(in_id) <= CALC_W'(alloc_r));
  assign id_m1    = CALC_W'(in_id) - CALC_W'(1);
  assign id_idx   = id_m1[IW-1:0];
  assign alloc_p1 = CALC_W'(alloc_r) + CALC_W'(1);
  assign ev_num   = CALC_W'(ev_idx_r) + CALC_W'(1);

  assign out_free = !out_vld_r || out_tready;
  assign any_main = |(running_r & ~source_r);

  // evaluation stage of the scan
  assign issue_more = (issue_idx_r < CW'(NUM_TIMERS));
  assign ev_due     = (rd_data_r.count >= rd_data_r.period);
  assign srv_hit    = is_srv_r && running_r[ev_idx_r] && ev_due &&
                      (nexp_r < NEXP_W'(MAX_RESULTS));
  assign tick_hit   = !is_srv_r && running_r[ev_idx_r] &&
                      (source_r[ev_idx_r] == tick_sub_r);
  assign stall      = ev_vld_r && srv_hit && pend_vld_r && !out_free;

  // memory read address: next slot, or hold the slot under evaluation
  assign rd_addr = ((state_r == ST_SCAN) && !stall && issue_more) ?
                   issue_idx_r[IW-1:0] : ev_idx_r;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    alloc_nxt     = alloc_r;
    running_nxt   = running_r;
    source_nxt    = source_r;
    is_srv_nxt    = is_srv_r;
    tick_sub_nxt  = tick_sub_r;
    issue_idx_nxt = issue_idx_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    nexp_nxt      = nexp_r;
    pend_vld_nxt  = pend_vld_r;
    pend_num_nxt  = pend_num_r;
    fin_ok_nxt    = fin_ok_r;
    fin_num_nxt   = fin_num_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_num_nxt   = out_num_r;
    out_exp_nxt   = out_exp_r;
    out_main_nxt  = out_main_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = ev_idx_r;
    mem_wdata     = rd_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pend_vld_nxt = 1'b0;
          fin_ok_nxt   = 1'b0;
          fin_num_nxt  = '0;
          state_nxt    = ST_DONE;
          unique case (in_mode)
            MODE_ALLOC: begin
              if (alloc_r < CW'(NUM_TIMERS)) begin
                alloc_nxt   = alloc_r + CW'(1);
                fin_ok_nxt  = 1'b1;
                fin_num_nxt = alloc_p1[ID_W-1:0];
              end
            end
            MODE_START: begin
              if (!in_src[1] && id_ok) begin
                running_nxt[id_idx] = 1'b1;
                source_nxt[id_idx]  = in_src[0];
                mem_we              = 1'b1;
                mem_waddr           = id_idx;
                mem_wdata.period    = in_per;
                mem_wdata.count     = '0;
                fin_ok_nxt          = 1'b1;
              end
            end
            MODE_CLOSE: begin
              if (id_ok) begin
                running_nxt[id_idx] = 1'b0;
                source_nxt[id_idx]  = 1'b0;
                fin_ok_nxt          = 1'b1;
              end
            end
            MODE_TICK_MAIN, MODE_TICK_SUB, MODE_SERVICE: begin
              fin_ok_nxt    = 1'b1;
              is_srv_nxt    = (in_mode == MODE_SERVICE);
              tick_sub_nxt  = (in_mode == MODE_TICK_SUB);
              issue_idx_nxt = '0;
              ev_vld_nxt    = 1'b0;
              nexp_nxt      = '0;
              state_nxt     = ST_SCAN;
            end
            default: begin
              fin_ok_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // advance the read pipeline by one slot
          ev_vld_nxt = issue_more;
          ev_idx_nxt = issue_idx_r[IW-1:0];
          if (issue_more) begin
            issue_idx_nxt = issue_idx_r + CW'(1);
          end
          // count update or expiry clear
          if (ev_vld_r && (tick_hit || srv_hit)) begin
            mem_we          = 1'b1;
            mem_waddr       = ev_idx_r;
            mem_wdata.count = tick_hit ? (rd_data_r.count + CNT_W'(1)) : '0;
          end
          // hold the newest expiry back, send the one before it
          if (ev_vld_r && srv_hit) begin
            nexp_nxt     = nexp_r + NEXP_W'(1);
            pend_vld_nxt = 1'b1;
            pend_num_nxt = ev_num[ID_W-1:0];
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_ok_nxt   = 1'b1;
              out_num_nxt  = pend_num_r;
              out_exp_nxt  = 1'b1;
              out_main_nxt = any_main;
              out_last_nxt = 1'b0;
            end
          end
          if (!ev_vld_r && !issue_more) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // final transaction of the item
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_ok_nxt   = fin_ok_r;
          out_num_nxt  = pend_vld_r ? pend_num_r : fin_num_r;
          out_exp_nxt  = pend_vld_r;
          out_main_nxt = any_main;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alloc_r     <= '0;
      running_r   <= '0;
      source_r    <= '0;
      is_srv_r    <= 1'b0;
      tick_sub_r  <= 1'b0;
      issue_idx_r <= '0;
      ev_vld_r    <= 1'b0;
      ev_idx_r    <= '0;
      nexp_r      <= '0;
      pend_vld_r  <= 1'b0;
      pend_num_r  <= '0;
      fin_ok_r    <= 1'b0;
      fin_num_r   <= '0;
      out_vld_r   <= 1'b0;
      out_ok_r    <= 1'b0;
      out_num_r   <= '0;
      out_exp_r   <= 1'b0;
      out_main_r  <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_r     <= alloc_nxt;
      running_r   <= running_nxt;
      source_r    <= source_nxt;
      is_srv_r    <= is_srv_nxt;
      tick_sub_r  <= tick_sub_nxt;
      issue_idx_r <= issue_idx_nxt;
      ev_vld_r    <= ev_vld_nxt;
      ev_idx_r    <= ev_idx_nxt;
      nexp_r      <= nexp_nxt;
      pend_vld_r  <= pend_vld_nxt;
      pend_num_r  <= pend_num_nxt;
      fin_ok_r    <= fin_ok_nxt;
      fin_num_r   <= fin_num_nxt;
      out_vld_r   <= out_vld_nxt;
      out_ok_r    <= out_ok_nxt;
      out_num_r   <= out_num_nxt;
      out_exp_r   <= out_exp_nxt;
      out_main_r  <= out_main_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // period/count memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // result channel
  always_comb begin
    out_tdata               = '0;
    out_tdata[OUT_OK_BIT]   = out_ok_r;
    out_tdata[OUT_NUM_LSB +: ID_W] = out_num_r;
    out_tdata[OUT_MAIN_BIT] = out_main_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_exp_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/mcstb_chk.sv -----
// port-level checker for the soft timer bank, bound to the top level
`include "assert_macros.svh"

module mcstb_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [mcstb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mcstb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);
  import mcstb_pkg::*;

  // a stalled result transaction holds its contents
  `MCSTB_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // an expiry report is always an accepted operation
  `MCSTB_ASSERT_IMP(a_exp_ok, clk, rst_n, out_tvalid && out_tuser, out_tdata[OUT_OK_BIT])

  // every result that is not an expiry closes its item
  `MCSTB_ASSERT_IMP(a_plain_last, clk, rst_n, out_tvalid && !out_tuser, out_tlast)

  // one item in flight: no new transaction right after one is taken
  `MCSTB_ASSERT_NXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind multi_channel_soft_timer_bank_unit mcstb_chk u_mcstb_chk (.*);

// ----- verif/tb_multi_channel_soft_timer_bank_unit.sv -----
// self-checking testbench for the soft timer bank: stream driver, result monitor, bank predictor
module tb_multi_channel_soft_timer_bank_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mcstb_pkg::*;

  localparam int NUM_SLOTS    = NUM_TIMERS_DEF;
  localparam int OPS_TOTAL    = 130;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 16;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AT_OP   = 60;
  localparam int QUIET_TAIL   = 16;

  // codes outside the package enum
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
  localparam logic [1:0] SRC_MAIN      = 2'd0;
  localparam logic [1:0] SRC_SUB       = 2'd1;
  localparam logic [1:0] SRC_BAD_2     = 2'd2;
  localparam logic [1:0] SRC_BAD_3     = 2'd3;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ID_W-1:0]  id;
    logic [SRC_W-1:0] src;
    logic [PER_W-1:0] period;
  } timer_op_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] num;
    logic            expired;
    logic            main_on;
    logic            last;
  } timer_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // pending stimulus and expected results
  timer_op_t     op_queue[$];
  timer_result_t expected_results[$];
  timer_op_t     in_op;
  bit            in_taken;
  int            ops_queued;
  int            ops_accepted;
  int            gen_alloc;
  int            error_count;
  int            cycle_count;
  int            gap_left;
  int            stall_left;
  bit            hold_done;

  // shadow copy of the bank state
  int               bank_alloc;
  logic             bank_running[NUM_SLOTS];
  logic             bank_src[NUM_SLOTS];
  logic [PER_W-1:0] bank_period[NUM_SLOTS];
  logic [CNT_W-1:0] bank_count[NUM_SLOTS];

  multi_channel_soft_timer_bank_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one expected result, main-running flag taken from the current shadow state
  function automatic void push_result(logic ok, logic [ID_W-1:0] num, logic expired,
                                      logic last);
    timer_result_t r;
    r.ok      = ok;
    r.num     = num;
    r.expired = expired;
    r.main_on = 1'b0;
    r.last    = last;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (bank_running[i] && bank_src[i] == 1'b0) begin
        r.main_on = 1'b1;
      end
    end
    expected_results.push_back(r);
  endfunction

  // update the shadow bank for one transaction and queue its results
  function automatic void timer_bank_predict(timer_op_t op);
    int hits;
    hits = 0;
    case (op.mode)
      MODE_ALLOC: begin
        if (bank_alloc < NUM_SLOTS) begin
          bank_alloc++;
          push_result(1'b1, ID_W'(bank_alloc), 1'b0, 1'b1);
        end else begin
          push_result(1'b0, '0, 1'b0, 1'b1);
        end
      end
      MODE_START: begin
        if (op.src >= SRC_BAD_2 || op.id == 0 || op.id > bank_alloc) begin
          push_result(1'b0, '0, 1'b0, 1'b1);
        end else begin
          bank_running[op.id - 1] = 1'b1;
          bank_src[op.id - 1]     = op.src[0];
          bank_period[op.id - 1]  = op.period;
          bank_count[op.id - 1]   = '0;
          push_result(1'b1, '0, 1'b0, 1'b1);
        end
      end
      MODE_CLOSE: begin
        if (op.id == 0 || op.id > bank_alloc) begin
          push_result(1'b0, '0, 1'b0, 1'b1);
        end else begin
          bank_running[op.id - 1] = 1'b0;
          bank_src[op.id - 1]     = 1'b0;
          bank_period[op.id - 1]  = '0;
          bank_count[op.id - 1]   = '0;
          push_result(1'b1, '0, 1'b0, 1'b1);
        end
      end
      MODE_TICK_MAIN, MODE_TICK_SUB: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_running[i] && bank_src[i] == (op.mode == MODE_TICK_SUB)) begin
            bank_count[i] = bank_count[i] + 1'b1;
          end
        end
        push_result(1'b1, '0, 1'b0, 1'b1);
      end
      MODE_SERVICE: begin
        for (int i = 0; i < NUM_SLOTS && hits < MAX_RESULTS; i++) begin
          if (bank_running[i] && bank_count[i] >= bank_period[i]) begin
            bank_count[i] = '0;
            push_result(1'b1, ID_W'(i + 1), 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          push_result(1'b1, '0, 1'b0, 1'b1);
        end else begin
          expected_results[expected_results.size() - 1].last = 1'b1;
        end
      end
      default: begin
        push_result(1'b0, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // append one transaction to the stimulus queue, tracking allocations as they will land
  function automatic void queue_op(logic [2:0] mode, logic [ID_W-1:0] id,
                                   logic [SRC_W-1:0] src, logic [PER_W-1:0] period);
    timer_op_t op;
    op.mode   = mode;
    op.id     = id;
    op.src    = src;
    op.period = period;
    op_queue.push_back(op);
    ops_queued++;
    if (mode == MODE_ALLOC && gen_alloc < NUM_SLOTS) begin
      gen_alloc++;
    end
  endfunction

  // mostly short periods so timers expire, sometimes full-width or all ones
  function automatic logic [PER_W-1:0] rand_period();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return PER_W'($urandom_range(0, 6));
    end else if (pick < 9) begin
      return PER_W'($urandom());
    end
    return '1;
  endfunction

  // stimulus, reset and end of run
  initial begin
    int  pick;
    int  a_lim;
    bit  bank_armed;
    logic [ID_W-1:0] id;
    logic [SRC_W-1:0] src;

    bank_armed = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      bank_running[i] = 1'b0;
      bank_src[i]     = 1'b0;
      bank_period[i]  = '0;
      bank_count[i]   = '0;
    end

    // directed: rejections, every operation, restart, close of an idle slot, period zero
    queue_op(MODE_START, 5'd1, SRC_MAIN, 32'd5);
    queue_op(MODE_CLOSE, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_SERVICE, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_ALLOC, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_ALLOC, 5'd31, SRC_BAD_3, 32'hFFFF_FFFF);
    queue_op(MODE_ALLOC, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_START, 5'd0, SRC_MAIN, 32'd3);
    queue_op(MODE_START, 5'd1, SRC_BAD_2, 32'd3);
    queue_op(MODE_START, 5'd1, SRC_BAD_3, 32'd3);
    queue_op(MODE_START, 5'd31, SRC_MAIN, 32'd3);
    queue_op(MODE_START, 5'd1, SRC_MAIN, 32'd0);
    queue_op(MODE_START, 5'd2, SRC_SUB, 32'd2);
    queue_op(MODE_START, 5'd3, SRC_MAIN, 32'hFFFF_FFFF);
    queue_op(MODE_TICK_SUB, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_TICK_SUB, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_TICK_MAIN, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_SERVICE, 5'd0, SRC_MAIN, 32'd0);
    queue_op(MODE_CLOSE, 5'd3, SRC_MAIN, 32'd0);
    queue_op(MODE_CLOSE, 5'd3, SRC_MAIN, 32'd0);
    queue_op(MODE_START, 5'd2, SRC_SUB, 32'd1);
    queue_op(MODE_UNUSED_6, 5'd1, SRC_MAIN, 32'd0);
    queue_op(MODE_UNUSED_7, 5'd1, SRC_MAIN, 32'd0);
    queue_op(MODE_CLOSE, 5'd4, SRC_MAIN, 32'd0);
    queue_op(MODE_SERVICE, 5'd0, SRC_MAIN, 32'd0);

    // random: mostly valid starts and ticks on allocated slots, some noise
    while (ops_queued < OPS_TOTAL) begin
      pick  = $urandom_range(0, 99);
      a_lim = (gen_alloc < NUM_SLOTS) ? 20 : 4;
      if (gen_alloc == NUM_SLOTS && !bank_armed) begin
        // arm every slot so one service reports the full bank
        bank_armed = 1'b1;
        for (int k = 1; k <= NUM_SLOTS; k++) begin
          queue_op(MODE_START, ID_W'(k), SRC_W'($urandom_range(0, 1)),
                   PER_W'($urandom_range(0, 1)));
        end
        queue_op(MODE_TICK_MAIN, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
        queue_op(MODE_TICK_SUB, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
        queue_op(MODE_SERVICE, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
      end else if (pick < a_lim) begin
        queue_op(MODE_ALLOC, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
      end else if (pick < a_lim + 26) begin
        if ($urandom_range(0, 99) < 15) begin
          id  = ID_W'($urandom_range(0, 31));
          src = SRC_W'($urandom_range(0, 3));
        end else begin
          id  = (gen_alloc == 0) ? ID_W'(1) : ID_W'($urandom_range(1, gen_alloc));
          src = SRC_W'($urandom_range(0, 1));
        end
        queue_op(MODE_START, id, src, rand_period());
      end else if (pick < a_lim + 34) begin
        if ($urandom_range(0, 99) < 15 || gen_alloc == 0) begin
          id = ID_W'($urandom_range(0, 31));
        end else begin
          id = ID_W'($urandom_range(1, gen_alloc));
        end
        queue_op(MODE_CLOSE, id, SRC_W'($urandom()), $urandom());
      end else if (pick < a_lim + 50) begin
        queue_op(MODE_TICK_MAIN, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
      end else if (pick < a_lim + 62) begin
        queue_op(MODE_TICK_SUB, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
      end else if (pick < a_lim + 76) begin
        queue_op(MODE_SERVICE, ID_W'($urandom()), SRC_W'($urandom()), $urandom());
      end else begin
        queue_op($urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7,
                 ID_W'($urandom()), SRC_W'($urandom()), $urandom());
      end
    end

    // synchronous reset, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every transaction to be taken and answered, then let the block settle
    while (ops_accepted < ops_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_multi_channel_soft_timer_bank_unit: PASS");
    end else begin
      $display("tb_multi_channel_soft_timer_bank_unit: FAIL");
    end
    $finish;
  end

  // input side: note accepted transactions and predict their results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      timer_bank_predict(in_op);
      ops_accepted++;
      in_taken = 1'b1;
    end
  end

  // input driver: next transaction or a short idle burst at the falling edge
  always @(negedge clk) begin
    logic [IN_TDATA_W-1:0] word;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left == 0 && op_queue.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 3);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        in_op = op_queue.pop_front();
        word  = '0;
        word[IN_MODE_LSB +: MODE_W] = in_op.mode;
        word[IN_ID_LSB +: ID_W]     = in_op.id;
        word[IN_SRC_LSB +: SRC_W]   = in_op.src;
        word[IN_PER_LSB +: PER_W]   = in_op.period;
        in_tdata  <= word;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side ready: random stall bursts and one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && ops_accepted >= HOLD_AT_OP) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (op_queue.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok      = out_tdata[OUT_OK_BIT];
      got.num     = out_tdata[OUT_NUM_LSB +: ID_W];
      got.expired = out_tuser;
      got.main_on = out_tdata[OUT_MAIN_BIT];
      got.last    = out_tlast;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          error_count++;
        end
        if (got.num !== want.num) begin
          $error("timer_number: expected %0d, got %0d", want.num, got.num);
          error_count++;
        end
        if (got.expired !== want.expired) begin
          $error("expired: expected %0d, got %0d", want.expired, got.expired);
          error_count++;
        end
        if (got.main_on !== want.main_on) begin
          $error("any_main_running: expected %0d, got %0d", want.main_on, got.main_on);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_multi_channel_soft_timer_bank_unit: FAIL");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mcstb_pkg.sv
hw/rtl/multi_channel_soft_timer_bank_unit.sv
hw/rtl/mcstb_chk.sv
verif/tb_multi_channel_soft_timer_bank_unit.sv
